### rtl/smou_pkg.sv
// Shared types, codes and constants of the stack machine operation unit.
package smou_pkg;

  localparam int DATA_W              = 64;
  localparam int DEPTH_FIELD_W       = 9;
  localparam int OP_W                = 4;
  localparam int STATUS_W            = 2;
  localparam int DEFAULT_STACK_DEPTH = 256;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH    = 4'd0,
    OP_DUP     = 4'd1,
    OP_POP     = 4'd2,
    OP_SWAP    = 4'd3,
    OP_PTR_ADD = 4'd4,
    OP_PTR_SUB = 4'd5,
    OP_EQ      = 4'd6,
    OP_NE      = 4'd7,
    OP_LT      = 4'd8,
    OP_LE      = 4'd9,
    OP_GT      = 4'd10,
    OP_GE      = 4'd11,
    OP_NOT     = 4'd12
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_IGNORED   = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Occupancy of the stack as seen by the execute logic.
  typedef struct packed {
    logic has_one;
    logic has_two;
    logic full;
  } stack_flags_t;

  // Decisions of the execute logic for one operation.
  typedef struct packed {
    status_t status;
    logic    set_fail;
    logic    sp_inc;
    logic    sp_dec;
    logic    top_load;
    logic    wr_en;
    logic    wr_second;
  } exec_ctrl_t;

endpackage

### rtl/smou_cmd_if.sv
// Command and response channel interfaces of the stack machine operation unit.
interface smou_cmd_if import smou_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, output op, output push_value, input ready);
  modport sink   (input valid, input op, input push_value, output ready);
endinterface

interface smou_rsp_if import smou_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] top_value;
  logic [DEPTH_FIELD_W-1:0] stack_depth;
  logic [STATUS_W-1:0]      status;
  logic                     failed;

  modport source (output valid, output top_value, output stack_depth, output status,
                  output failed, input ready);
  modport sink   (input valid, input top_value, input stack_depth, input status,
                  input failed, output ready);
endinterface

### rtl/smou_stack_ram.sv
// Single-port-write, single-port-read stack RAM with a registered read.
module smou_stack_ram import smou_pkg::*; #(
  parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH,
  parameter int AW          = $clog2(STACK_DEPTH)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/smou_alu.sv
// Execute logic: checks occupancy, decides the stack update and computes the new top.
module smou_alu import smou_pkg::*; (
  input  logic [OP_W-1:0]   op,
  input  logic [DATA_W-1:0] push_value,
  input  logic [DATA_W-1:0] top,
  input  logic [DATA_W-1:0] second,
  input  stack_flags_t      flags,
  input  logic              failed,
  output exec_ctrl_t        ctrl,
  output logic [DATA_W-1:0] result
);

  logic [DATA_W-1:0] arith;
  logic              lt;
  logic              gt;
  logic              eq;

  // The operand below the top is a, the top is b.
  assign lt = $signed(second) < $signed(top);
  assign gt = $signed(top) < $signed(second);
  assign eq = second == top;

  always_comb begin
    arith = '0;
    case (op_t'(op))
      OP_PTR_ADD: arith = second + top;
      OP_PTR_SUB: arith = second - top;
      OP_EQ:      arith = DATA_W'(eq);
      OP_NE:      arith = DATA_W'(!eq);
      OP_LT:      arith = DATA_W'(lt);
      OP_LE:      arith = DATA_W'(!gt);
      OP_GT:      arith = DATA_W'(gt);
      OP_GE:      arith = DATA_W'(!lt);
      default:    arith = '0;
    endcase
  end

  always_comb begin
    ctrl   = '{status: ST_OK, default: 1'b0};
    result = top;
    if (failed) begin
      ctrl.status = ST_IGNORED;
    end else begin
      case (op_t'(op))
        OP_PUSH: begin
          if (flags.full) begin
            ctrl.status   = ST_OVERFLOW;
            ctrl.set_fail = 1'b1;
          end else begin
            ctrl.wr_en    = flags.has_one;
            ctrl.sp_inc   = 1'b1;
            ctrl.top_load = 1'b1;
            result        = push_value;
          end
        end
        OP_DUP: begin
          if (!flags.has_one) begin
            ctrl.status   = ST_UNDERFLOW;
            ctrl.set_fail = 1'b1;
          end else if (flags.full) begin
            ctrl.status   = ST_OVERFLOW;
            ctrl.set_fail = 1'b1;
          end else begin
            ctrl.wr_en  = 1'b1;
            ctrl.sp_inc = 1'b1;
          end
        end
        OP_POP: begin
          if (!flags.has_one) begin
            ctrl.status   = ST_UNDERFLOW;
            ctrl.set_fail = 1'b1;
          end else begin
            ctrl.sp_dec   = 1'b1;
            ctrl.top_load = 1'b1;
            result        = second;
          end
        end
        OP_NOT: begin
          if (!flags.has_one) begin
            ctrl.status   = ST_UNDERFLOW;
            ctrl.set_fail = 1'b1;
          end else begin
            ctrl.top_load = 1'b1;
            result        = DATA_W'(top == '0);
          end
        end
        OP_SWAP: begin
          if (!flags.has_two) begin
            ctrl.status   = ST_UNDERFLOW;
            ctrl.set_fail = 1'b1;
          end else begin
            ctrl.wr_en     = 1'b1;
            ctrl.wr_second = 1'b1;
            ctrl.top_load  = 1'b1;
            result         = second;
          end
        end
        OP_PTR_ADD, OP_PTR_SUB, OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE: begin
          if (!flags.has_two) begin
            ctrl.status   = ST_UNDERFLOW;
            ctrl.set_fail = 1'b1;
          end else begin
            ctrl.sp_dec   = 1'b1;
            ctrl.top_load = 1'b1;
            result        = arith;
          end
        end
        default: begin
          // Undefined opcodes leave everything as it is and report ok.
          ctrl.status = ST_OK;
        end
      endcase
    end
  end

endmodule

### rtl/stack_machine_operation_unit.sv
// Top level of the stack machine operation unit: sequencer, top register and output stage.
//
// Each command beat runs one stack operation on a stack of STACK_DEPTH 64-bit entries and
// yields one response beat carrying the new top of stack (0 when the stack is empty), the
// depth modulo 512, a status code and the sticky failure flag. In the accept cycle the entry
// below the top is read from the stack RAM, whose read is registered, and in the S_EXEC
// state the operation executes, writes the RAM back and loads the response register.
// Commands are accepted only in S_IDLE, so a new command is not taken before the last one
// has executed; a stalled response holds the execute cycle until the response register
// frees up. The top of stack lives in a register, so the RAM only holds the entries below
// it, and no clearing pass is needed after reset. Once an underflow or overflow sets the
// failure flag, every later operation is ignored until reset.
module stack_machine_operation_unit import smou_pkg::*; #(
  parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
  input logic        clk,
  input logic        rst,
  smou_cmd_if.sink   cmd,
  smou_rsp_if.source rsp
);

  localparam int SP_W = $clog2(STACK_DEPTH + 1);
  localparam int AW   = $clog2(STACK_DEPTH);

  state_t state;
  state_t state_next;

  // Stack pointer counts entries; the top entry is held in top, the rest in the RAM.
  logic [SP_W-1:0]   sp;
  logic [SP_W-1:0]   sp_next;
  logic [DATA_W-1:0] top;
  logic              failed;

  logic [OP_W-1:0]   op_q;
  logic [DATA_W-1:0] push_value_q;

  logic [SP_W-1:0]   sp_minus1;
  logic [SP_W-1:0]   sp_minus2;
  logic [DATA_W-1:0] second;
  logic              rd_en;
  logic              commit;
  logic [AW-1:0]     wr_addr;

  stack_flags_t      flags;
  exec_ctrl_t        ctrl;
  logic [DATA_W-1:0] result;

  assign sp_minus1 = sp - SP_W'(1);
  assign sp_minus2 = sp - SP_W'(2);

  assign flags.has_one = sp != '0;
  assign flags.has_two = sp > SP_W'(1);
  assign flags.full    = sp == SP_W'(STACK_DEPTH);

  // The read of the entry below the top starts with the command beat itself.
  assign rd_en   = cmd.valid && cmd.ready;
  // Push and dup spill the old top to the slot above the RAM's current top;
  // swap puts the old top into the slot it takes the second entry from.
  assign wr_addr = ctrl.wr_second ? sp_minus2[AW-1:0] : sp_minus1[AW-1:0];

  smou_stack_ram #(
    .STACK_DEPTH (STACK_DEPTH),
    .AW          (AW)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (sp_minus2[AW-1:0]),
    .rd_data (second),
    .wr_en   (commit && ctrl.wr_en),
    .wr_addr (wr_addr),
    .wr_data (top)
  );

  smou_alu u_alu (
    .op         (op_q),
    .push_value (push_value_q),
    .top        (top),
    .second     (second),
    .flags      (flags),
    .failed     (failed),
    .ctrl       (ctrl),
    .result     (result)
  );

  always_comb begin
    sp_next = sp;
    if (ctrl.sp_inc) begin
      sp_next = sp + SP_W'(1);
    end else if (ctrl.sp_dec) begin
      sp_next = sp_minus1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.ready  = 1'b0;
    commit     = 1'b0;
    case (state)
      S_IDLE: begin
        cmd.ready = 1'b1;
        if (cmd.valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        // Execute only when the response register can take the result.
        if (!rsp.valid || rsp.ready) begin
          commit     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp        <= '0;
      failed    <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (commit) begin
        sp        <= sp_next;
        failed    <= failed || ctrl.set_fail;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      op_q         <= cmd.op;
      push_value_q <= cmd.push_value;
    end
    if (commit) begin
      if (ctrl.top_load) begin
        top <= result;
      end
      rsp.top_value   <= (sp_next != '0) ? result : '0;
      rsp.stack_depth <= DEPTH_FIELD_W'(sp_next);
      rsp.status      <= ctrl.status;
      rsp.failed      <= failed || ctrl.set_fail;
    end
  end

`ifndef SYNTHESIS
  a_sp_in_range: assert property (@(posedge clk) disable iff (rst)
    sp <= SP_W'(STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  a_fail_sticky: assert property (@(posedge clk) disable iff (rst)
    failed |=> failed)
    else $error("failure flag cleared without reset");

  a_sp_moves_on_commit: assert property (@(posedge clk) disable iff (rst)
    !commit |=> $stable(sp))
    else $error("stack pointer changed outside an execute cycle");

  a_ignored_when_failed: assert property (@(posedge clk) disable iff (rst)
    commit && failed |=> rsp.status == ST_IGNORED && rsp.failed)
    else $error("operation after failure not reported as ignored");

  a_commit_needs_room: assert property (@(posedge clk) disable iff (rst)
    commit |-> state == S_EXEC && (!rsp.valid || rsp.ready))
    else $error("result committed while response register is occupied");
`endif

endmodule
